FILE: design/spe_pkg.sv
// Shared types and constants for the sector peak envelope points block.
package spe_pkg;

   localparam logic [8:0]  MAX_POINTS  = 9'd256;
   localparam logic [10:0] MAX_SAMPLES = 11'd1024;

   localparam int QUEUE_DEPTH = 4;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] REG_POINT_COUNT   = 2'd2;
   localparam logic [1:0] REG_SAMPLE_COUNT  = 2'd3;

   typedef struct packed {
      logic [11:0] screen_width;
      logic [11:0] screen_height;
      logic [8:0]  point_count;
      logic [10:0] sample_count;
   } cfg_type;

   // one pending curve point between front and back
   typedef struct packed {
      logic [7:0]        index;
      logic [11:0]       spacing;
      logic signed [7:0] peak;
      logic              last;
   } point_entry_type;

endpackage

FILE: design/spe_divider.sv
// Restoring divider, one quotient bit per cycle, 12-bit dividend by 9-bit divisor.
module spe_divider
   import spe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [11:0] dividend,
   input  logic [8:0]  divisor,
   output logic        done,
   output logic [11:0] quotient
);

   logic [11:0] dvd_ff, dvd_in;
   logic [11:0] quo_ff, quo_in;
   logic [8:0]  rem_ff, rem_in;
   logic [3:0]  count_ff, count_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [9:0]  rem_shift;

   always_comb begin
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      rem_shift = {rem_ff, dvd_ff[11]};
      if (start) begin
         dvd_in   = dividend;
         quo_in   = '0;
         rem_in   = '0;
         count_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[10:0], 1'b0};
         if (rem_shift >= {1'b0, divisor}) begin
            rem_in = 9'(rem_shift - {1'b0, divisor});
            quo_in = {quo_ff[10:0], 1'b1};
         end else begin
            rem_in = rem_shift[8:0];
            quo_in = {quo_ff[10:0], 1'b0};
         end
         count_in = count_ff + 4'd1;
         if (count_ff == 4'd11) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/spe_front.sv
// Front end: frame setup, sample acceptance, sector counters and peak tracking.
module spe_front
   import spe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            cfg_write,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_sample,
   input  logic            queue_full,
   output logic            push,
   output point_entry_type push_entry
);

   localparam logic [1:0] SETUP_IDLE = 2'd0;
   localparam logic [1:0] SETUP_DIV  = 2'd1;
   localparam logic [1:0] SETUP_SPAN = 2'd2;

   // setup sequencer
   logic [1:0]  setup_ff, setup_in;
   logic        start_ff, start_in;
   logic [8:0]  pts_clamp;
   logic [10:0] sc_clamp;
   logic        len_done, spc_done;
   logic [11:0] len_quo, spc_quo;
   logic [8:0]  pend_pts_ff, pend_pts_in;
   logic [10:0] pend_len_ff, pend_len_in;
   logic [11:0] pend_spc_ff, pend_spc_in;
   logic [10:0] pend_flen_ff, pend_flen_in;
   logic [19:0] span;
   logic        busy;

   // frame state
   logic [10:0]       frame_pos_ff, frame_pos_in;
   logic [10:0]       within_ff, within_in;
   logic [8:0]        sector_ff, sector_in;
   logic signed [7:0] peak_ff, peak_in;
   logic [8:0]        act_pts_ff, act_pts_in;
   logic [10:0]       act_len_ff, act_len_in;
   logic [11:0]       act_spc_ff, act_spc_in;
   logic [10:0]       act_flen_ff, act_flen_in;

   logic              accept, first;
   logic [8:0]        use_pts;
   logic [10:0]       use_len, use_flen;
   logic [11:0]       use_spc;
   logic signed [7:0] sample_s, mag, new_peak;
   logic [10:0]       within_inc, frame_inc;

   always_comb begin
      if (cfg.point_count < 9'd2) pts_clamp = 9'd2;
      else if (cfg.point_count > MAX_POINTS) pts_clamp = MAX_POINTS;
      else pts_clamp = cfg.point_count;
      if (cfg.sample_count == 11'd0) sc_clamp = 11'd1;
      else if (cfg.sample_count > MAX_SAMPLES) sc_clamp = MAX_SAMPLES;
      else sc_clamp = cfg.sample_count;
   end

   spe_divider u_len_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend ({1'b0, sc_clamp}),
      .divisor  (pts_clamp),
      .done     (len_done),
      .quotient (len_quo)
   );

   spe_divider u_spc_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (cfg.screen_width),
      .divisor  (9'(pts_clamp - 9'd1)),
      .done     (spc_done),
      .quotient (spc_quo)
   );

   assign span = pend_pts_ff * pend_len_ff;

   always_comb begin
      setup_in     = setup_ff;
      start_in     = cfg_write;
      pend_pts_in  = pend_pts_ff;
      pend_len_in  = pend_len_ff;
      pend_spc_in  = pend_spc_ff;
      pend_flen_in = pend_flen_ff;
      case (setup_ff)
         SETUP_IDLE: begin
            if (start_ff) setup_in = SETUP_DIV;
         end
         SETUP_DIV: begin
            if (len_done && spc_done) begin
               pend_pts_in = pts_clamp;
               pend_len_in = (len_quo == 12'd0) ? 11'd1 : len_quo[10:0];
               pend_spc_in = spc_quo;
               setup_in    = SETUP_SPAN;
            end
         end
         SETUP_SPAN: begin
            pend_flen_in = (span > {9'd0, sc_clamp}) ? span[10:0] : sc_clamp;
            setup_in     = SETUP_IDLE;
         end
         default: setup_in = SETUP_IDLE;
      endcase
      // a new write restarts the whole computation
      if (start_ff) setup_in = SETUP_DIV;
   end

   assign busy      = start_ff || (setup_ff != SETUP_IDLE);
   assign req_ready = !busy && !queue_full;
   assign accept    = req_valid && req_ready;
   assign first     = (frame_pos_ff == 11'd0);

   assign use_pts  = first ? pend_pts_ff  : act_pts_ff;
   assign use_len  = first ? pend_len_ff  : act_len_ff;
   assign use_spc  = first ? pend_spc_ff  : act_spc_ff;
   assign use_flen = first ? pend_flen_ff : act_flen_ff;

   // magnitude wraps in 8 bits: -128 stays -128
   assign sample_s   = req_sample;
   assign mag        = sample_s[7] ? 8'(~sample_s + 8'sd1) : sample_s;
   assign new_peak   = (mag > peak_ff) ? mag : peak_ff;
   assign within_inc = within_ff + 11'd1;
   assign frame_inc  = frame_pos_ff + 11'd1;

   always_comb begin
      frame_pos_in = frame_pos_ff;
      within_in    = within_ff;
      sector_in    = sector_ff;
      peak_in      = peak_ff;
      act_pts_in   = act_pts_ff;
      act_len_in   = act_len_ff;
      act_spc_in   = act_spc_ff;
      act_flen_in  = act_flen_ff;
      push         = 1'b0;
      push_entry.index   = sector_ff[7:0];
      push_entry.spacing = use_spc;
      push_entry.peak    = new_peak;
      push_entry.last    = ({1'b0, sector_ff} + 10'd1) == {1'b0, use_pts};
      if (accept) begin
         if (first) begin
            act_pts_in  = pend_pts_ff;
            act_len_in  = pend_len_ff;
            act_spc_in  = pend_spc_ff;
            act_flen_in = pend_flen_ff;
         end
         if (sector_ff < use_pts) begin
            if (within_inc >= use_len) begin
               push      = 1'b1;
               sector_in = sector_ff + 9'd1;
               within_in = '0;
               peak_in   = -8'sd128;
            end else begin
               within_in = within_inc;
               peak_in   = new_peak;
            end
         end
         frame_pos_in = frame_inc;
         if (frame_inc >= use_flen) begin
            frame_pos_in = '0;
            within_in    = '0;
            sector_in    = '0;
            peak_in      = -8'sd128;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff     <= SETUP_IDLE;
         start_ff     <= 1'b1;
         frame_pos_ff <= '0;
         within_ff    <= '0;
         sector_ff    <= '0;
         peak_ff      <= -8'sd128;
      end else begin
         setup_ff     <= setup_in;
         start_ff     <= start_in;
         frame_pos_ff <= frame_pos_in;
         within_ff    <= within_in;
         sector_ff    <= sector_in;
         peak_ff      <= peak_in;
      end
      pend_pts_ff  <= pend_pts_in;
      pend_len_ff  <= pend_len_in;
      pend_spc_ff  <= pend_spc_in;
      pend_flen_ff <= pend_flen_in;
      act_pts_ff   <= act_pts_in;
      act_len_ff   <= act_len_in;
      act_spc_ff   <= act_spc_in;
      act_flen_ff  <= act_flen_in;
   end

endmodule

FILE: design/spe_queue.sv
// Small flip-flop FIFO of pending curve points between front and back.
module spe_queue
   import spe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  point_entry_type push_entry,
   input  logic            pop,
   output logic            full,
   output logic            not_empty,
   output point_entry_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   point_entry_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> !full) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue pop while empty");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");
`endif

endmodule

FILE: design/spe_back.sv
// Back end: point coordinate arithmetic and the result output register.
module spe_back
   import spe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [11:0]     screen_height,
   input  logic            entry_valid,
   input  point_entry_type entry,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [7:0]      rsp_point_index,
   output logic [11:0]     rsp_x_pos,
   output logic [18:0]     rsp_y_times_128,
   output logic            rsp_last_point
);

   logic        valid_ff, valid_in;
   logic [7:0]  index_ff;
   logic [11:0] x_ff;
   logic [18:0] y_ff;
   logic        last_ff;
   logic [11:0] half_height;
   logic [7:0]  level;
   logic [19:0] x_prod, y_prod;

   // curve height is the lower half, rounded up
   assign half_height = screen_height - {1'b0, screen_height[11:1]};
   // peak + 128 for a signed byte is its sign bit flipped
   assign level  = {~entry.peak[7], entry.peak[6:0]};
   assign x_prod = entry.index * entry.spacing;
   assign y_prod = half_height * level;

   assign pop = entry_valid && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      if (pop) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (pop) begin
         index_ff <= entry.index;
         x_ff     <= x_prod[11:0];
         y_ff     <= y_prod[18:0];
         last_ff  <= entry.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_point_index = index_ff;
   assign rsp_x_pos       = x_ff;
   assign rsp_y_times_128 = y_ff;
   assign rsp_last_point  = last_ff;

endmodule

FILE: design/sector_peak_envelope_points_core.sv
// Top level of the sector peak envelope points block: register file and module wiring.
//
// Takes one signed 8-bit sample per transaction, tracks the peak magnitude of
// each of point_count equal sectors of a capture frame, and emits one curve
// point (index, x, y*128, last flag) at the end of each sector. Throughput is
// one sample per cycle: the front end updates its registered counters and
// peak on each accepted sample and hands finished points through a
// four-entry queue to the back end, whose two multipliers feed a registered
// output. Input stalls only when the queue is full, or after reset and after
// every register write, while two bit-serial dividers (one quotient bit a
// cycle) and a span multiply derive the sector length, point spacing and
// frame length. Those values are taken up at the first sample of each frame,
// so a write in mid-frame applies from the next frame; screen_height is used
// live. Registers sit at byte addresses 0 (width), 4 (height), 8 (points) and
// 12 (samples); writes complete in the APB access phase, pready is tied high.
module sector_peak_envelope_points_core
   import spe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // sample channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_sample,
   // point channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_point_index,
   output logic [11:0] rsp_x_pos,
   output logic [18:0] rsp_y_times_128,
   output logic        rsp_last_point,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type         cfg_ff, cfg_in;
   logic            cfg_write;
   logic            push, pop, q_full, q_not_empty;
   point_entry_type push_entry, q_head;

   // register file
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (paddr[3:2])
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = pwdata[11:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = pwdata[11:0];
            REG_POINT_COUNT:   cfg_in.point_count   = pwdata[8:0];
            REG_SAMPLE_COUNT:  cfg_in.sample_count  = pwdata[10:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SCREEN_WIDTH:  prdata = {20'd0, cfg_ff.screen_width};
         REG_SCREEN_HEIGHT: prdata = {20'd0, cfg_ff.screen_height};
         REG_POINT_COUNT:   prdata = {23'd0, cfg_ff.point_count};
         REG_SAMPLE_COUNT:  prdata = {21'd0, cfg_ff.sample_count};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= 12'd1024;
         cfg_ff.screen_height <= 12'd512;
         cfg_ff.point_count   <= 9'd32;
         cfg_ff.sample_count  <= 11'd1024;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sample intake, sector counting and peak tracking
   spe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cfg_write  (cfg_write),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .queue_full (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouples the per-sample front from the result side
   spe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // coordinates and output register
   spe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .screen_height   (cfg_ff.screen_height),
      .entry_valid     (q_not_empty),
      .entry           (q_head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_index (rsp_point_index),
      .rsp_x_pos       (rsp_x_pos),
      .rsp_y_times_128 (rsp_y_times_128),
      .rsp_last_point  (rsp_last_point)
   );

endmodule
